// ===== sv/tgad_pkg.sv =====
// ----------------------------------------------------------------------------
// tgad_pkg
// Types and constants shared by the TGA stream decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tgad_pkg;

    // Parsing phase of the byte stream.
    typedef enum logic [3:0] {
        PH_IDLEN,
        PH_CMAP,
        PH_ITYPE,
        PH_SKIP,
        PH_WLO,
        PH_WHI,
        PH_HLO,
        PH_HHI,
        PH_DEPTH,
        PH_DESC,
        PH_IDSKIP,
        PH_PACKET,
        PH_PIXEL,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_CMAP  = 2'd1,
        ERR_ITYPE = 2'd2,
        ERR_DEPTH = 2'd3
    } error_code_t;

    localparam logic [7:0] CMAP_REJECTED = 8'd1;
    localparam logic [7:0] ITYPE_RAW     = 8'd2;
    localparam logic [7:0] ITYPE_RLE     = 8'd10;
    localparam logic [7:0] DEPTH_RGB     = 8'd24;
    localparam logic [7:0] DEPTH_RGBA    = 8'd32;
    // Index of the last of the nine skipped header bytes.
    localparam logic [3:0] SKIP_LAST_IDX = 4'd8;
    localparam logic [6:0] RLE_COUNT_MASK = 7'h7F;
    localparam int unsigned RLE_RUN_BIT  = 7;

    typedef struct packed {
        result_kind_t kind;
        logic [31:0]  pixel_value;
        logic [7:0]   repeat_count;
        logic [15:0]  image_width;
        logic [15:0]  image_height;
        logic         has_alpha;
        error_code_t  error_code;
        logic         last;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/tgad_byte_if.sv =====
// ----------------------------------------------------------------------------
// tgad_byte_if
// Valid/ready channel carrying one byte of the TGA file per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgad_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/tgad_result_if.sv =====
// ----------------------------------------------------------------------------
// tgad_result_if
// Valid/ready channel carrying one decoder result per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgad_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic [1:0]  error_code;
    logic        last;

    modport source (
        output valid, output result_kind, output pixel_value, output repeat_count,
        output image_width, output image_height, output has_alpha,
        output error_code, output last, input ready
    );
    modport sink (
        input valid, input result_kind, input pixel_value, input repeat_count,
        input image_width, input image_height, input has_alpha,
        input error_code, input last, output ready
    );
endinterface

`default_nettype wire

// ===== sv/tgad_core.sv =====
// ----------------------------------------------------------------------------
// tgad_core
// Header and pixel parser: consumes one byte per step and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tgad_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      data_byte,
    output logic                 res_emit,
    output tgad_pkg::result_t    res
);

    tgad_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  hdr_idx_reg,    hdr_idx_next;
    logic [7:0]  id_left_reg,    id_left_next;
    logic [15:0] width_reg,      width_next;
    logic [15:0] height_reg,     height_next;
    logic        rle_reg,        rle_next;
    logic        alpha_reg,      alpha_next;
    logic        run_reg,        run_next;
    logic [7:0]  pkt_left_reg,   pkt_left_next;
    logic [31:0] assembly_reg,   assembly_next;
    logic [1:0]  pix_idx_reg,    pix_idx_next;
    logic [31:0] pixels_left_reg, pixels_left_next;
    logic [31:0] area_reg;

    logic        header_done;
    logic        image_empty;
    logic [1:0]  pix_top;
    logic        pix_complete;
    logic [31:0] assembled;
    logic [7:0]  rep_raw;
    logic [7:0]  rep;
    logic [31:0] pixels_after;
    logic [7:0]  pkt_after;
    logic [7:0]  pkt_count;
    logic [7:0]  pkt_clamped;

    // Shared decode of the current byte.
    always_comb
    begin
        header_done  = ((phase_reg == tgad_pkg::PH_DESC) && (id_left_reg == 8'd0)) ||
                       ((phase_reg == tgad_pkg::PH_IDSKIP) && (id_left_reg == 8'd1));
        image_empty  = (width_reg == 16'd0) || (height_reg == 16'd0);
        pix_top      = alpha_reg ? 2'd3 : 2'd2;
        pix_complete = (pix_idx_reg == pix_top);
        case (pix_idx_reg)
            2'd0:    assembled = assembly_reg | {24'd0, data_byte};
            2'd1:    assembled = assembly_reg | {16'd0, data_byte, 8'd0};
            2'd2:    assembled = assembly_reg | {8'd0, data_byte, 16'd0};
            default: assembled = assembly_reg | {data_byte, 24'd0};
        endcase
        rep_raw      = (rle_reg && run_reg) ? pkt_left_reg : 8'd1;
        rep          = ({24'd0, rep_raw} > pixels_left_reg) ? pixels_left_reg[7:0] : rep_raw;
        pixels_after = pixels_left_reg - {24'd0, rep};
        pkt_after    = pkt_left_reg - rep;
        pkt_count    = {1'b0, data_byte[6:0] & tgad_pkg::RLE_COUNT_MASK} + 8'd1;
        pkt_clamped  = ({24'd0, pkt_count} > pixels_left_reg) ?
                       pixels_left_reg[7:0] : pkt_count;
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg) inside
                tgad_pkg::PH_IDLEN:  phase_next = tgad_pkg::PH_CMAP;
                tgad_pkg::PH_CMAP:
                    phase_next = (data_byte == tgad_pkg::CMAP_REJECTED) ?
                                 tgad_pkg::PH_ERROR : tgad_pkg::PH_ITYPE;
                tgad_pkg::PH_ITYPE:
                    phase_next = ((data_byte == tgad_pkg::ITYPE_RAW) ||
                                  (data_byte == tgad_pkg::ITYPE_RLE)) ?
                                 tgad_pkg::PH_SKIP : tgad_pkg::PH_ERROR;
                tgad_pkg::PH_SKIP:
                    if (hdr_idx_reg >= tgad_pkg::SKIP_LAST_IDX)
                    begin
                        phase_next = tgad_pkg::PH_WLO;
                    end
                tgad_pkg::PH_WLO:    phase_next = tgad_pkg::PH_WHI;
                tgad_pkg::PH_WHI:    phase_next = tgad_pkg::PH_HLO;
                tgad_pkg::PH_HLO:    phase_next = tgad_pkg::PH_HHI;
                tgad_pkg::PH_HHI:    phase_next = tgad_pkg::PH_DEPTH;
                tgad_pkg::PH_DEPTH:
                    phase_next = ((data_byte == tgad_pkg::DEPTH_RGB) ||
                                  (data_byte == tgad_pkg::DEPTH_RGBA)) ?
                                 tgad_pkg::PH_DESC : tgad_pkg::PH_ERROR;
                tgad_pkg::PH_DESC, tgad_pkg::PH_IDSKIP:
                    if (header_done)
                    begin
                        if (image_empty)
                            phase_next = tgad_pkg::PH_DONE;
                        else
                            phase_next = rle_reg ? tgad_pkg::PH_PACKET : tgad_pkg::PH_PIXEL;
                    end
                    else
                    begin
                        phase_next = tgad_pkg::PH_IDSKIP;
                    end
                tgad_pkg::PH_PACKET: phase_next = tgad_pkg::PH_PIXEL;
                tgad_pkg::PH_PIXEL:
                    if (pix_complete)
                    begin
                        if (pixels_after == 32'd0)
                            phase_next = tgad_pkg::PH_DONE;
                        else if (rle_reg && (pkt_after == 8'd0))
                            phase_next = tgad_pkg::PH_PACKET;
                    end
                default:             phase_next = phase_reg;
            endcase
        end
    end

    // Datapath registers and the result.
    always_comb
    begin
        hdr_idx_next     = hdr_idx_reg;
        id_left_next     = id_left_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        rle_next         = rle_reg;
        alpha_next       = alpha_reg;
        run_next         = run_reg;
        pkt_left_next    = pkt_left_reg;
        assembly_next    = assembly_reg;
        pix_idx_next     = pix_idx_reg;
        pixels_left_next = pixels_left_reg;

        res_emit          = 1'b0;
        res.kind          = tgad_pkg::KIND_HEADER;
        res.pixel_value   = 32'd0;
        res.repeat_count  = 8'd0;
        res.image_width   = width_reg;
        res.image_height  = height_reg;
        res.has_alpha     = alpha_reg;
        res.error_code    = tgad_pkg::ERR_NONE;
        res.last          = 1'b0;

        if (step)
        begin
            unique case (phase_reg) inside
                tgad_pkg::PH_IDLEN:
                    id_left_next = data_byte;
                tgad_pkg::PH_CMAP:
                    if (data_byte == tgad_pkg::CMAP_REJECTED)
                    begin
                        res_emit       = 1'b1;
                        res.kind       = tgad_pkg::KIND_ERROR;
                        res.error_code = tgad_pkg::ERR_CMAP;
                        res.last       = 1'b1;
                    end
                tgad_pkg::PH_ITYPE:
                    if (data_byte == tgad_pkg::ITYPE_RAW || data_byte == tgad_pkg::ITYPE_RLE)
                    begin
                        rle_next     = (data_byte == tgad_pkg::ITYPE_RLE);
                        hdr_idx_next = 4'd0;
                    end
                    else
                    begin
                        res_emit       = 1'b1;
                        res.kind       = tgad_pkg::KIND_ERROR;
                        res.error_code = tgad_pkg::ERR_ITYPE;
                        res.last       = 1'b1;
                    end
                tgad_pkg::PH_SKIP:
                    hdr_idx_next = hdr_idx_reg + 4'd1;
                tgad_pkg::PH_WLO:
                    width_next = {8'd0, data_byte};
                tgad_pkg::PH_WHI:
                    width_next = {data_byte, width_reg[7:0]};
                tgad_pkg::PH_HLO:
                    height_next = {8'd0, data_byte};
                tgad_pkg::PH_HHI:
                    height_next = {data_byte, height_reg[7:0]};
                tgad_pkg::PH_DEPTH:
                    if (data_byte == tgad_pkg::DEPTH_RGB || data_byte == tgad_pkg::DEPTH_RGBA)
                    begin
                        alpha_next = (data_byte == tgad_pkg::DEPTH_RGBA);
                    end
                    else
                    begin
                        res_emit       = 1'b1;
                        res.kind       = tgad_pkg::KIND_ERROR;
                        res.error_code = tgad_pkg::ERR_DEPTH;
                        res.last       = 1'b1;
                    end
                tgad_pkg::PH_DESC, tgad_pkg::PH_IDSKIP:
                begin
                    if (phase_reg == tgad_pkg::PH_IDSKIP)
                        id_left_next = id_left_reg - 8'd1;
                    if (header_done)
                    begin
                        pixels_left_next = area_reg;
                        assembly_next    = 32'd0;
                        pix_idx_next     = 2'd0;
                        pkt_left_next    = 8'd0;
                        run_next         = 1'b0;
                        res_emit         = 1'b1;
                        res.last         = image_empty;
                    end
                end
                tgad_pkg::PH_PACKET:
                begin
                    run_next      = data_byte[tgad_pkg::RLE_RUN_BIT];
                    pkt_left_next = pkt_clamped;
                    assembly_next = 32'd0;
                    pix_idx_next  = 2'd0;
                end
                tgad_pkg::PH_PIXEL:
                    if (pix_complete)
                    begin
                        assembly_next    = 32'd0;
                        pix_idx_next     = 2'd0;
                        pixels_left_next = pixels_after;
                        if (rle_reg)
                            pkt_left_next = pkt_after;
                        res_emit         = 1'b1;
                        res.kind         = tgad_pkg::KIND_PIXEL;
                        res.pixel_value  = assembled;
                        res.repeat_count = rep;
                        res.last         = (pixels_after == 32'd0);
                    end
                    else
                    begin
                        assembly_next = assembled;
                        pix_idx_next  = pix_idx_reg + 2'd1;
                    end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= tgad_pkg::PH_IDLEN;
            hdr_idx_reg     <= 4'd0;
            id_left_reg     <= 8'd0;
            width_reg       <= 16'd0;
            height_reg      <= 16'd0;
            rle_reg         <= 1'b0;
            alpha_reg       <= 1'b0;
            run_reg         <= 1'b0;
            pkt_left_reg    <= 8'd0;
            assembly_reg    <= 32'd0;
            pix_idx_reg     <= 2'd0;
            pixels_left_reg <= 32'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            hdr_idx_reg     <= hdr_idx_next;
            id_left_reg     <= id_left_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            rle_reg         <= rle_next;
            alpha_reg       <= alpha_next;
            run_reg         <= run_next;
            pkt_left_reg    <= pkt_left_next;
            assembly_reg    <= assembly_next;
            pix_idx_reg     <= pix_idx_next;
            pixels_left_reg <= pixels_left_next;
        end
    end

    // The pixel count is formed while the depth and descriptor bytes go by,
    // so the multiplier sits alone between the geometry and area registers.
    always_ff @(posedge clk)
    begin
        area_reg <= {16'd0, width_reg} * {16'd0, height_reg};
    end

endmodule

`default_nettype wire

// ===== sv/tga_image_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_image_stream_decoder
// A result is on the output register in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the result side keeps up, set by the
// single parse stage and the output register. Reset is asynchronous and
// returns the parser to waiting for the ID length byte with no result held.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_image_stream_decoder (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tgad_byte_if.sink     byte_stream,
    tgad_result_if.source results
);

    // A byte request is taken whenever the output register is empty or is
    // being emptied in the same cycle, so the parser never waits on a
    // result that the downstream side is draining at full rate.
    logic               accept;
    logic               res_emit;
    tgad_pkg::result_t  res;
    logic               out_valid_reg, out_valid_next;
    tgad_pkg::result_t  out_reg;

    assign byte_stream.ready = !out_valid_reg || results.ready;
    assign accept            = byte_stream.valid && byte_stream.ready;

    // The parser updates its state on every accepted byte and says whether
    // that byte completes a result (header, pixel run or error).
    tgad_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept),
        .data_byte (byte_stream.data_byte),
        .res_emit  (res_emit),
        .res       (res)
    );

    // The output register fills on a producing byte and drains when the
    // downstream side takes the result request.
    always_comb
    begin
        if (accept && res_emit)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // The payload needs no reset: it is only looked at while valid is high.
    always_ff @(posedge clk)
    begin
        if (accept && res_emit)
            out_reg <= res;
    end

    assign results.valid        = out_valid_reg;
    assign results.result_kind  = out_reg.kind;
    assign results.pixel_value  = out_reg.pixel_value;
    assign results.repeat_count = out_reg.repeat_count;
    assign results.image_width  = out_reg.image_width;
    assign results.image_height = out_reg.image_height;
    assign results.has_alpha    = out_reg.has_alpha;
    assign results.error_code   = out_reg.error_code;
    assign results.last         = out_reg.last;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the TGA stream decoder. One TGA file per run is
// built from random content: a well-formed raw or run-length image most of the
// time, otherwise a file that breaks in the header or describes an empty
// image. Each accepted byte is decoded by a model of the parser kept in the
// bench, and every result leaving the block is compared field by field with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no request on either channel before the run is abandoned.
    localparam int unsigned STALL_LIMIT  = 2000;
    // The result side holds ready low for this stretch of its own cycles. It
    // starts straight after reset so that even a lone header or error result
    // waits long enough for the byte side to back up.
    localparam int unsigned HOLD_START   = 1;
    localparam int unsigned HOLD_LEN     = 400;
    // Window of cycles in which neither side inserts random idle cycles.
    localparam int unsigned QUIET_START  = 1200;
    localparam int unsigned QUIET_END    = 1700;
    // Idle probability in percent outside the quiet window.
    localparam int unsigned IDLE_PERCENT = 32;
    // Cycles to keep watching the output once nothing more is expected.
    localparam int unsigned TAIL_CYCLES  = 10;
    // Number of bytes a file is padded up to with trailing bytes.
    localparam int unsigned ITEM_TARGET  = 1900;

    typedef enum int {
        SCN_CMAP_ERR,
        SCN_ITYPE_ERR,
        SCN_DEPTH_ERR,
        SCN_EMPTY,
        SCN_IMAGE
    } scenario_t;

    typedef enum int {
        PIX_RANDOM,
        PIX_ZERO,
        PIX_ONES
    } pixel_style_t;

    // One byte waiting to be offered. When hold_for_drain is set, the byte is
    // not offered until every predicted result has been seen.
    typedef struct {
        logic [7:0] data;
        bit         hold_for_drain;
    } file_byte_t;

    logic clk;
    logic rst_n;

    tgad_byte_if   byte_bus ();
    tgad_result_if result_bus ();

    tga_image_stream_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_bus),
        .results     (result_bus)
    );

    file_byte_t          file_bytes[$];
    tgad_pkg::result_t   expected_results[$];

    int unsigned mismatches;
    int unsigned bytes_accepted;
    int unsigned results_checked;
    int unsigned pixel_results;
    int unsigned stall_cycles;
    int unsigned driver_cycles;
    int unsigned sink_cycles;

    // ------------------------------------------------------------------------
    // Parser model. Set once in main_sequence, these mirror the decoder state
    // and then change only in decode_byte and its helpers, in the byte driver.
    // ------------------------------------------------------------------------
    tgad_pkg::phase_t dec_phase;
    logic [3:0]  dec_skip_idx;
    logic [7:0]  dec_id_left;
    logic [15:0] dec_width;
    logic [15:0] dec_height;
    logic        dec_rle;
    logic        dec_alpha;
    logic        dec_run;
    logic [7:0]  dec_pkt_left;
    logic [31:0] dec_pix;
    logic [1:0]  dec_byte_idx;
    logic [31:0] dec_pixels_left;

    // Every result carries the geometry and alpha flag as known at that point.
    function automatic tgad_pkg::result_t form_result(tgad_pkg::result_kind_t kind,
                                                      logic [31:0] pix, logic [7:0] rep,
                                                      tgad_pkg::error_code_t err,
                                                      logic lst);
        tgad_pkg::result_t r;
        r.kind         = kind;
        r.pixel_value  = pix;
        r.repeat_count = rep;
        r.image_width  = dec_width;
        r.image_height = dec_height;
        r.has_alpha    = dec_alpha;
        r.error_code   = err;
        r.last         = lst;
        return r;
    endfunction

    // The header result goes out on the last header byte. An image with no
    // pixels is finished right there, so that result is also marked last.
    function automatic tgad_pkg::result_t close_header();
        dec_pixels_left = {16'd0, dec_width} * {16'd0, dec_height};
        dec_pix         = '0;
        dec_byte_idx    = '0;
        dec_pkt_left    = '0;
        dec_run         = 1'b0;
        if (dec_pixels_left == 0)
        begin
            dec_phase = tgad_pkg::PH_DONE;
            return form_result(tgad_pkg::KIND_HEADER, '0, '0, tgad_pkg::ERR_NONE, 1'b1);
        end
        dec_phase = dec_rle ? tgad_pkg::PH_PACKET : tgad_pkg::PH_PIXEL;
        return form_result(tgad_pkg::KIND_HEADER, '0, '0, tgad_pkg::ERR_NONE, 1'b0);
    endfunction

    function automatic tgad_pkg::result_t reject(tgad_pkg::error_code_t err);
        dec_phase = tgad_pkg::PH_ERROR;
        return form_result(tgad_pkg::KIND_ERROR, '0, '0, err, 1'b1);
    endfunction

    // Advances the model by one byte. Returns 1 when the byte yields a result.
    function automatic bit decode_byte(input logic [7:0] b, output tgad_pkg::result_t r);
        logic [31:0] n;
        logic [31:0] rep;
        logic [31:0] pixel;
        logic        lst;
        bit          produced;
        produced = 1'b0;
        r        = '0;
        case (dec_phase)
            tgad_pkg::PH_IDLEN:
            begin
                dec_id_left = b;
                dec_phase   = tgad_pkg::PH_CMAP;
            end
            tgad_pkg::PH_CMAP:
            begin
                // Only the colour-mapped type is refused; any other value passes.
                if (b == tgad_pkg::CMAP_REJECTED)
                begin
                    r        = reject(tgad_pkg::ERR_CMAP);
                    produced = 1'b1;
                end
                else
                    dec_phase = tgad_pkg::PH_ITYPE;
            end
            tgad_pkg::PH_ITYPE:
            begin
                if (b == tgad_pkg::ITYPE_RAW || b == tgad_pkg::ITYPE_RLE)
                begin
                    dec_rle      = (b == tgad_pkg::ITYPE_RLE);
                    dec_skip_idx = '0;
                    dec_phase    = tgad_pkg::PH_SKIP;
                end
                else
                begin
                    r        = reject(tgad_pkg::ERR_ITYPE);
                    produced = 1'b1;
                end
            end
            tgad_pkg::PH_SKIP:
            begin
                dec_skip_idx = dec_skip_idx + 4'd1;
                if (dec_skip_idx > tgad_pkg::SKIP_LAST_IDX)
                    dec_phase = tgad_pkg::PH_WLO;
            end
            tgad_pkg::PH_WLO:
            begin
                dec_width = {8'd0, b};
                dec_phase = tgad_pkg::PH_WHI;
            end
            tgad_pkg::PH_WHI:
            begin
                dec_width[15:8] = b;
                dec_phase       = tgad_pkg::PH_HLO;
            end
            tgad_pkg::PH_HLO:
            begin
                dec_height = {8'd0, b};
                dec_phase  = tgad_pkg::PH_HHI;
            end
            tgad_pkg::PH_HHI:
            begin
                dec_height[15:8] = b;
                dec_phase        = tgad_pkg::PH_DEPTH;
            end
            tgad_pkg::PH_DEPTH:
            begin
                if (b == tgad_pkg::DEPTH_RGB || b == tgad_pkg::DEPTH_RGBA)
                begin
                    dec_alpha = (b == tgad_pkg::DEPTH_RGBA);
                    dec_phase = tgad_pkg::PH_DESC;
                end
                else
                begin
                    r        = reject(tgad_pkg::ERR_DEPTH);
                    produced = 1'b1;
                end
            end
            tgad_pkg::PH_DESC:
            begin
                if (dec_id_left == 0)
                begin
                    r        = close_header();
                    produced = 1'b1;
                end
                else
                    dec_phase = tgad_pkg::PH_IDSKIP;
            end
            tgad_pkg::PH_IDSKIP:
            begin
                dec_id_left = dec_id_left - 8'd1;
                if (dec_id_left == 0)
                begin
                    r        = close_header();
                    produced = 1'b1;
                end
            end
            tgad_pkg::PH_PACKET:
            begin
                // Packet counts are clamped to what is left of the image.
                n = {25'd0, b[6:0] & tgad_pkg::RLE_COUNT_MASK} + 32'd1;
                if (n > dec_pixels_left)
                    n = dec_pixels_left;
                dec_run      = b[tgad_pkg::RLE_RUN_BIT];
                dec_pkt_left = n[7:0];
                dec_pix      = '0;
                dec_byte_idx = '0;
                dec_phase    = tgad_pkg::PH_PIXEL;
            end
            tgad_pkg::PH_PIXEL:
            begin
                dec_pix = dec_pix | ({24'd0, b} << (8 * dec_byte_idx));
                if (dec_byte_idx < (dec_alpha ? 2'd3 : 2'd2))
                    dec_byte_idx = dec_byte_idx + 2'd1;
                else
                begin
                    pixel        = dec_pix;
                    dec_pix      = '0;
                    dec_byte_idx = '0;
                    rep = (dec_rle && dec_run) ? {24'd0, dec_pkt_left} : 32'd1;
                    if (rep > dec_pixels_left)
                        rep = dec_pixels_left;
                    dec_pixels_left = dec_pixels_left - rep;
                    if (dec_rle)
                    begin
                        dec_pkt_left = dec_pkt_left - rep[7:0];
                        if (dec_pkt_left == 0)
                            dec_phase = tgad_pkg::PH_PACKET;
                    end
                    lst = (dec_pixels_left == 0);
                    if (lst)
                        dec_phase = tgad_pkg::PH_DONE;
                    r        = form_result(tgad_pkg::KIND_PIXEL, pixel, rep[7:0],
                                           tgad_pkg::ERR_NONE, lst);
                    produced = 1'b1;
                end
            end
            default:
            begin
                // Finished or failed: bytes are swallowed until reset.
            end
        endcase
        return produced;
    endfunction

    // ------------------------------------------------------------------------
    // File construction helpers.
    // ------------------------------------------------------------------------
    function automatic void push_byte(logic [7:0] v);
        file_byte_t fb;
        fb.data           = v;
        fb.hold_for_drain = 1'b0;
        file_bytes.push_back(fb);
    endfunction

    // By style, pixel bytes are all zero, all one, or mostly random with all-zero and all-one bytes mixed in.
    function automatic void push_pixel(int unsigned nbytes, pixel_style_t style);
        logic [7:0] v;
        for (int unsigned i = 0; i < nbytes; i++)
        begin
            if (style == PIX_ZERO)
                v = 8'h00;
            else if (style == PIX_ONES)
                v = 8'hFF;
            else if ($urandom_range(0, 15) == 0)
                v = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            else
                v = 8'($urandom_range(0, 255));
            push_byte(v);
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                 want);
        mismatches++;
    endtask

    // Compares one accepted result against the oldest prediction.
    task automatic check_result();
        tgad_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with nothing outstanding",
                            32'(result_bus.result_kind), 32'd0);
            return;
        end
        want = expected_results.pop_front();
        results_checked++;
        if (result_bus.result_kind !== want.kind)
            report_mismatch("result_kind", 32'(result_bus.result_kind), 32'(want.kind));
        if (result_bus.pixel_value !== want.pixel_value)
            report_mismatch("pixel_value", result_bus.pixel_value, want.pixel_value);
        if (result_bus.repeat_count !== want.repeat_count)
            report_mismatch("repeat_count", 32'(result_bus.repeat_count),
                            32'(want.repeat_count));
        if (result_bus.image_width !== want.image_width)
            report_mismatch("image_width", 32'(result_bus.image_width),
                            32'(want.image_width));
        if (result_bus.image_height !== want.image_height)
            report_mismatch("image_height", 32'(result_bus.image_height),
                            32'(want.image_height));
        if (result_bus.has_alpha !== want.has_alpha)
            report_mismatch("has_alpha", 32'(result_bus.has_alpha), 32'(want.has_alpha));
        if (result_bus.error_code !== want.error_code)
            report_mismatch("error_code", 32'(result_bus.error_code), 32'(want.error_code));
        if (result_bus.last !== want.last)
            report_mismatch("last", 32'(result_bus.last), 32'(want.last));
    endtask

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Byte driver. At each edge it first hands an accepted request to the
    // parser model, so that predictions exist before the block can answer,
    // and then decides what to offer next. valid and data_byte each receive at
    // most one nonblocking assignment per edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : byte_driver
        tgad_pkg::result_t r;
        file_byte_t        fb;
        bit                offer;
        bit                idle;
        if (!rst_n)
        begin
            byte_bus.valid <= 1'b0;
        end
        else
        begin
            driver_cycles++;
            if (byte_bus.valid && byte_bus.ready)
            begin
                bytes_accepted++;
                if (decode_byte(byte_bus.data_byte, r))
                    expected_results.push_back(r);
            end
            if (!byte_bus.valid || byte_bus.ready)
            begin
                offer = 1'b0;
                idle  = !(driver_cycles >= QUIET_START && driver_cycles < QUIET_END) &&
                        ($urandom_range(0, 99) < IDLE_PERCENT);
                if (file_bytes.size() != 0)
                begin
                    // A marked byte waits until the block has answered everything.
                    if (file_bytes[0].hold_for_drain && expected_results.size() == 0)
                        file_bytes[0].hold_for_drain = 1'b0;
                    offer = !file_bytes[0].hold_for_drain && !idle;
                end
                byte_bus.valid <= offer;
                if (offer)
                begin
                    fb = file_bytes.pop_front();
                    byte_bus.data_byte <= fb.data;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result sink. It checks every accepted result and drives ready, with
    // random idle cycles, a quiet window, and one long hold-off counted on its
    // own cycles, during which the sender keeps offering so the block backs up.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_sink
        bit holding;
        bit idle;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else
        begin
            sink_cycles++;
            if (result_bus.valid && result_bus.ready)
            begin
                if (result_bus.result_kind == tgad_pkg::KIND_PIXEL)
                    pixel_results++;
                check_result();
            end
            holding = (sink_cycles >= HOLD_START && sink_cycles < HOLD_START + HOLD_LEN);
            idle    = !(sink_cycles >= QUIET_START && sink_cycles < QUIET_END) &&
                      ($urandom_range(0, 99) < IDLE_PERCENT);
            result_bus.ready <= !holding && !idle;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when neither channel completes a request for too
    // long, which also catches predictions that never get their result.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((byte_bus.valid && byte_bus.ready) || (result_bus.valid && result_bus.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no request completed for %0d cycles", $realtime,
                         STALL_LIMIT);
                $display("tga_image_stream_decoder regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence. Since the decoder only leaves its finished or failed
    // states through reset, and reset is applied once, a run covers one file.
    // The seed chooses whether that file is a full image (raw or run-length,
    // 24 or 32 bits), an empty image, or one of the three header rejections.
    // Every file is padded with trailing bytes to at least the same overall length.
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        scenario_t    scn;
        int unsigned  pick;
        int unsigned  id_len;
        int unsigned  width;
        int unsigned  height;
        int unsigned  bpp;
        int unsigned  remaining;
        int unsigned  take;
        int unsigned  budget;
        int unsigned  packets;
        bit           rle_file;
        bit           alpha_file;
        logic [7:0]   v;
        logic [7:0]   count_byte;
        pixel_style_t style;

        rst_n                = 1'b0;
        byte_bus.valid       = 1'b0;
        byte_bus.data_byte   = '0;
        result_bus.ready     = 1'b0;
        mismatches           = 0;
        bytes_accepted       = 0;
        results_checked      = 0;
        pixel_results        = 0;
        stall_cycles         = 0;
        driver_cycles        = 0;
        sink_cycles          = 0;

        // Model reset state.
        dec_phase       = tgad_pkg::PH_IDLEN;
        dec_skip_idx    = '0;
        dec_id_left     = '0;
        dec_width       = '0;
        dec_height      = '0;
        dec_rle         = 1'b0;
        dec_alpha       = 1'b0;
        dec_run         = 1'b0;
        dec_pkt_left    = '0;
        dec_pix         = '0;
        dec_byte_idx    = '0;
        dec_pixels_left = '0;

        pick       = $urandom_range(0, 19);
        scn        = (pick < 4) ? scenario_t'(pick) : SCN_IMAGE;
        rle_file   = ($urandom_range(0, 1) != 0);
        alpha_file = ($urandom_range(0, 1) != 0);
        bpp        = alpha_file ? 4 : 3;
        width      = 0;
        height     = 0;

        // ID length: zero takes the short path to the header result, 255 is
        // the longest ID field.
        if ($urandom_range(0, 3) == 0)
            id_len = 0;
        else if ($urandom_range(0, 7) == 0)
            id_len = 255;
        else
            id_len = $urandom_range(1, 24);
        push_byte(id_len[7:0]);

        // Colour-map type: anything but the rejected value must be tolerated.
        if (scn == SCN_CMAP_ERR)
            push_byte(tgad_pkg::CMAP_REJECTED);
        else
        begin
            do
                v = 8'($urandom_range(0, 255));
            while (v == tgad_pkg::CMAP_REJECTED);
            push_byte(v);
        end

        if (scn != SCN_CMAP_ERR)
        begin
            if (scn == SCN_ITYPE_ERR)
            begin
                do
                    v = 8'($urandom_range(0, 255));
                while (v == tgad_pkg::ITYPE_RAW || v == tgad_pkg::ITYPE_RLE);
                push_byte(v);
            end
            else
                push_byte(rle_file ? tgad_pkg::ITYPE_RLE : tgad_pkg::ITYPE_RAW);
        end

        if (scn != SCN_CMAP_ERR && scn != SCN_ITYPE_ERR)
        begin
            repeat (9) push_byte(8'($urandom_range(0, 255)));

            // Geometry. Images are sized so that the pixel data mostly fits
            // in the file length; run-length files sometimes use a wide
            // single row so that the upper width bits are exercised.
            if (scn == SCN_EMPTY)
            begin
                if ($urandom_range(0, 1) != 0)
                    height = $urandom_range(0, 65535);
                else
                    width = $urandom_range(0, 65535);
            end
            else if (rle_file && $urandom_range(0, 3) == 0)
            begin
                width  = $urandom_range(256, 65535);
                height = 1;
            end
            else
            begin
                width  = rle_file ? $urandom_range(1, 300) : $urandom_range(1, 80);
                height = (rle_file ? $urandom_range(1500, 3500) : 1700 / bpp) / width;
                if (height == 0)
                    height = 1;
            end
            push_byte(width[7:0]);
            push_byte(width[15:8]);
            push_byte(height[7:0]);
            push_byte(height[15:8]);

            if (scn == SCN_DEPTH_ERR)
            begin
                do
                    v = 8'($urandom_range(0, 255));
                while (v == tgad_pkg::DEPTH_RGB || v == tgad_pkg::DEPTH_RGBA);
                push_byte(v);
            end
            else
                push_byte(alpha_file ? tgad_pkg::DEPTH_RGBA : tgad_pkg::DEPTH_RGB);
        end

        if (scn == SCN_EMPTY || scn == SCN_IMAGE)
        begin
            push_byte(8'($urandom_range(0, 255)));
            repeat (id_len) push_byte(8'($urandom_range(0, 255)));
        end

        if (scn == SCN_IMAGE)
        begin
            remaining = width * height;
            budget    = ITEM_TARGET + 300;
            packets   = 0;
            // A very wide image may not finish within the byte budget; it is
            // then simply left truncated.
            while (remaining != 0 && file_bytes.size() < budget)
            begin
                if (!rle_file)
                begin
                    // The first two raw pixels are the all-zero and all-one extremes.
                    style = (packets == 0) ? PIX_ZERO : (packets == 1) ? PIX_ONES : PIX_RANDOM;
                    push_pixel(bpp, style);
                    remaining--;
                    packets++;
                end
                else
                begin
                    // Opening packets: shortest run, longest run, single
                    // literal and a short literal. After that, random packets
                    // leaning towards runs, and near the end of the image an
                    // oversized count so that clamping is hit.
                    case (packets)
                        0:
                        begin
                            count_byte = 8'h80;
                            style      = PIX_ZERO;
                        end
                        1:
                        begin
                            count_byte = 8'hFF;
                            style      = PIX_ONES;
                        end
                        2:
                        begin
                            count_byte = 8'h00;
                            style      = PIX_ONES;
                        end
                        3:
                        begin
                            count_byte = 8'h03;
                            style      = PIX_RANDOM;
                        end
                        default:
                        begin
                            style      = PIX_RANDOM;
                            count_byte = '0;
                            count_byte[tgad_pkg::RLE_RUN_BIT] = ($urandom_range(0, 9) < 6);
                            if (remaining < 128 && $urandom_range(0, 1) != 0)
                                count_byte[6:0] = tgad_pkg::RLE_COUNT_MASK;
                            else if (count_byte[tgad_pkg::RLE_RUN_BIT])
                                count_byte[6:0] = 7'($urandom_range(0, 127));
                            else if ($urandom_range(0, 11) == 0)
                                count_byte[6:0] = tgad_pkg::RLE_COUNT_MASK;
                            else
                                count_byte[6:0] = 7'($urandom_range(0, 15));
                        end
                    endcase
                    push_byte(count_byte);
                    take = {25'd0, count_byte[6:0]} + 32'd1;
                    if (take > remaining)
                        take = remaining;
                    if (count_byte[tgad_pkg::RLE_RUN_BIT])
                        push_pixel(bpp, style);
                    else
                        repeat (take) push_pixel(bpp, style);
                    remaining -= take;
                    packets++;
                end
            end
        end

        // Trailing bytes after the end of the image or after a rejection;
        // the block must swallow them without producing anything.
        repeat ($urandom_range(4, 24)) push_byte(8'($urandom_range(0, 255)));
        while (file_bytes.size() < ITEM_TARGET)
            push_byte(8'($urandom_range(0, 255)));

        // Once during the run the sender pauses until everything is answered.
        file_bytes[(file_bytes.size() * 2) / 3].hold_for_drain = 1'b1;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (file_bytes.size() != 0 || byte_bus.valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("File kind %s, %s, %0d-bit, %0dx%0d: %0d bytes accepted.", scn.name(),
                 rle_file ? "run-length" : "raw", bpp * 8, width, height, bytes_accepted);
        $display("%0d results checked, %0d of them pixel results.", results_checked,
                 pixel_results);
        if (mismatches == 0)
            $display("tga_image_stream_decoder regression: pass");
        else
            $display("tga_image_stream_decoder regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/tgad_pkg.sv
sv/tgad_byte_if.sv
sv/tgad_result_if.sv
sv/tgad_core.sv
sv/tga_image_stream_decoder.sv
dv/testbench.sv
